FILE: sv/sorted_point_queue_core_macros.svh
// Assertion macros for the sorted point queue checker.
// Depends on nothing; included by the checker file.
`ifndef SORTED_POINT_QUEUE_CORE_MACROS_SVH
`define SORTED_POINT_QUEUE_CORE_MACROS_SVH

// Checked only outside reset.
`define SPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/spq_pkg.sv
// Shared types and constants for the sorted point queue.
// No dependencies; used by every module of the block.
package spq_pkg;

  localparam int OFFSET_BITS    = 16;
  localparam int VALUE_W        = 64;
  localparam int INDEX_W        = 16;
  localparam int POS_W          = 5;
  localparam int MAX_POINTS_DEF = 16;
  localparam int IN_DATA_W      = 96;
  localparam int OUT_DATA_W     = 96;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [VALUE_W-1:0]     value;
  } entry_t;

  // Write strobes broadcast to all cells.
  typedef struct packed {
    logic upd;  // replace value at matching offset
    logic ins;  // insert new point, shift later entries up
  } cell_ctl_t;

  typedef struct packed {
    logic lt;    // occupied and offset below the new one
    logic eq;    // occupied and offset equal to the new one
    logic here;  // first cell not below the new offset
  } cell_stat_t;

endpackage

FILE: sv/sorted_point_queue_core.sv
// Sorted point queue top level: chain of spq_cell slots plus result register.
// Depends on spq_pkg and spq_cell.
//
// Keeps up to MAX_POINTS (offset, value) points in ascending offset order.
// Every cell compares its offset with the new one at once and the whole chain
// shifts on the accepting edge, so add, get and clear all sustain one beat per
// clock unless the output stalls. The result comes out of a register in the
// cycle after the input beat and s_tready stays high while that register is
// empty or being drained. Adding a new offset to a full list returns status
// full and stores nothing; an equal offset always replaces the stored value.
module sorted_point_queue_core #(
  parameter int MAX_POINTS = spq_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] sample_offset, [79:16] point_value, [95:80] point_index
  input  logic [spq_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] func
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] status, [6:2] position, [22:7] found_offset, [86:23] found_value,
  // [91:87] point_count, [95:92] zero
  output logic [spq_pkg::OUT_DATA_W-1:0] m_tdata
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = INDEX_W + CNT_W;
  localparam int EXT_W = CNT_W + POS_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  op_t                    op;
  logic                   accept;
  logic [OFFSET_BITS-1:0] in_offset;
  logic [VALUE_W-1:0]     in_value;
  logic [INDEX_W-1:0]     in_index;

  entry_t     new_entry;
  cell_ctl_t  ctl;
  entry_t     entries [MAX_POINTS];
  cell_stat_t stats   [MAX_POINTS];

  logic             hit;
  logic             full;
  logic [CNT_W-1:0] ins_pos;
  logic             idx_ok;
  entry_t           rd_entry;

  status_t                status_next;
  logic [POS_W-1:0]       position_next;
  logic [OFFSET_BITS-1:0] found_offset_next;
  logic [VALUE_W-1:0]     found_value_next;

  assign op        = op_t'(s_tuser);
  assign in_offset = s_tdata[15:0];
  assign in_value  = s_tdata[79:16];
  assign in_index  = s_tdata[95:80];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  assign new_entry.offset = in_offset;
  assign new_entry.value  = in_value;

  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_cell
      if (g == 0) begin : g_first
        spq_cell #(.CNT_W(CNT_W), .CELL_IDX(g)) u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .new_entry (new_entry),
          .count     (count),
          .prev_lt   (1'b1),
          .prev_entry(new_entry),
          .entry     (entries[g]),
          .stat      (stats[g])
        );
      end else begin : g_rest
        spq_cell #(.CNT_W(CNT_W), .CELL_IDX(g)) u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .new_entry (new_entry),
          .count     (count),
          .prev_lt   (stats[g-1].lt),
          .prev_entry(entries[g-1]),
          .entry     (entries[g]),
          .stat      (stats[g])
        );
      end
    end
  endgenerate

  // Lower bound is a one-hot mark across the chain; gather hit, position, read.
  always_comb begin
    hit      = 1'b0;
    ins_pos  = '0;
    rd_entry = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      hit = hit | stats[i].eq;
      if (stats[i].here) begin
        ins_pos = ins_pos | CNT_W'(i);
      end
      if (in_index == INDEX_W'(i)) begin
        rd_entry = rd_entry | entries[i];
      end
    end
  end

  assign full   = count == CNT_W'(MAX_POINTS);
  assign idx_ok = CMP_W'(in_index) < CMP_W'(count);

  always_comb begin
    ctl.upd           = 1'b0;
    ctl.ins           = 1'b0;
    count_next        = count;
    status_next       = ST_OK;
    position_next     = '0;
    found_offset_next = '0;
    found_value_next  = '0;
    case (op)
      OP_ADD: begin
        if (hit) begin
          ctl.upd       = accept;
          position_next = POS_W'(EXT_W'(ins_pos));
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins       = accept;
          count_next    = count + 1'b1;
          position_next = POS_W'(EXT_W'(ins_pos));
        end
      end
      OP_GET: begin
        position_next = in_index[POS_W-1:0];
        if (idx_ok) begin
          found_offset_next = rd_entry.offset;
          found_value_next  = rd_entry.value;
        end else begin
          status_next = ST_BAD_INDEX;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata[1:0]   <= status_next;
      m_tdata[6:2]   <= position_next;
      m_tdata[22:7]  <= found_offset_next;
      m_tdata[86:23] <= found_value_next;
      m_tdata[91:87] <= POS_W'(EXT_W'(count_next));
      m_tdata[95:92] <= '0;
    end
  end

endmodule

FILE: sv/spq_cell.sv
// One slot of the sorted point chain: holds an entry, compares it to the
// broadcast offset, on insert takes new or lower neighbor's entry. Uses spq_pkg.
module spq_cell #(
  parameter int CNT_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_entry,
  input  logic [CNT_W-1:0]   count,
  input  logic               prev_lt,
  input  spq_pkg::entry_t    prev_entry,
  output spq_pkg::entry_t    entry,
  output spq_pkg::cell_stat_t stat
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  logic occ;
  logic lt;
  logic here;

  assign occ  = MY_IDX < count;
  assign lt   = occ && (entry.offset < new_entry.offset);
  assign here = prev_lt && !lt;

  assign stat.lt   = lt;
  assign stat.eq   = occ && (entry.offset == new_entry.offset);
  assign stat.here = here;

  always_ff @(posedge clk) begin
    if (ctl.upd && here) begin
      entry.value <= new_entry.value;
    end else if (ctl.ins) begin
      if (here) begin
        entry <= new_entry;
      end else if (!prev_lt) begin
        entry <= prev_entry;
      end
    end
  end

endmodule

FILE: sv/spq_checker.sv
// Port-level checker for sorted_point_queue_core, bound to the top level.
// Depends on spq_pkg and sorted_point_queue_core_macros.svh.
`include "sorted_point_queue_core_macros.svh"

module spq_checker #(
  parameter int MAX_POINTS = spq_pkg::MAX_POINTS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [spq_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [1:0]                     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [spq_pkg::OUT_DATA_W-1:0] m_tdata
);
  import spq_pkg::*;

  logic clear_beat;
  logic full_beat;
  logic bad_beat;

  assign clear_beat = s_tvalid && s_tready && (s_tuser == OP_CLEAR);
  assign full_beat  = m_tvalid && (m_tdata[1:0] == ST_FULL);
  assign bad_beat   = m_tvalid && (m_tdata[1:0] == ST_BAD_INDEX);

  `SPQ_ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !m_tvalid, "result beat right after reset")
  `SPQ_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")
  `SPQ_ASSERT(a_clear_empties, clk, rst, clear_beat |=> m_tvalid && (m_tdata[91:87] == '0), "clear left points")
  `SPQ_ASSERT(a_full_clean, clk, rst, full_beat |-> (m_tdata[86:2] == '0), "full result carries data")
  `SPQ_ASSERT(a_bad_clean, clk, rst, bad_beat |-> (m_tdata[86:7] == '0), "bad index result carries data")

endmodule

bind sorted_point_queue_core spq_checker #(.MAX_POINTS(MAX_POINTS)) u_spq_checker (.*);

FILE: sim/spq_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the sorted point queue: tracks accepted input beats, keeps
// its own sorted point list and compares every output beat. Depends on spq_pkg.
module spq_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  output int          pending,
  output int          errors,
  output int          replaces,
  output int          full_drops,
  output int          bad_gets
);
  import spq_pkg::*;

  localparam int MAX_PTS = MAX_POINTS_DEF;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  position;
    logic [15:0] found_offset;
    logic [63:0] found_value;
    logic [4:0]  point_count;
  } point_reply_t;

  logic [15:0]  list_offsets [MAX_PTS];
  logic [63:0]  list_values [MAX_PTS];
  int           list_count = 0;
  point_reply_t queued_replies [$];
  int           error_tally = 0;
  int           replace_tally = 0;
  int           drop_tally = 0;
  int           bad_get_tally = 0;

  assign replaces   = replace_tally;
  assign full_drops = drop_tally;
  assign bad_gets   = bad_get_tally;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_tally++;
    if (error_tally <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Applies one operation to the list copy and returns the reply it should produce.
  function automatic point_reply_t apply_point_op(input logic [1:0] func,
                                                  input logic [15:0] off,
                                                  input logic [63:0] val,
                                                  input logic [15:0] idx);
    point_reply_t r;
    int p;
    int k;
    r = '0;
    r.status = ST_OK;
    case (func)
      OP_ADD: begin
        p = 0;
        while (p < list_count && list_offsets[p] < off) p++;
        if (p < list_count && list_offsets[p] == off) begin
          list_values[p] = val;
          r.position = p[4:0];
          replace_tally++;
        end else if (list_count >= MAX_PTS) begin
          r.status = ST_FULL;
          drop_tally++;
        end else begin
          for (k = list_count; k > p; k--) begin
            list_offsets[k] = list_offsets[k-1];
            list_values[k]  = list_values[k-1];
          end
          list_offsets[p] = off;
          list_values[p]  = val;
          list_count++;
          r.position = p[4:0];
        end
      end
      OP_GET: begin
        r.position = idx[4:0];
        if (int'(idx) < list_count) begin
          r.found_offset = list_offsets[idx];
          r.found_value  = list_values[idx];
        end else begin
          r.status = ST_BAD_INDEX;
          bad_get_tally++;
        end
      end
      OP_CLEAR: list_count = 0;
      default: ;  // unused code leaves the list alone
    endcase
    r.point_count = list_count[4:0];
    return r;
  endfunction

  always @(posedge clk) begin : track
    point_reply_t want;
    point_reply_t fresh;
    if (rst) begin
      list_count = 0;
      queued_replies.delete();
    end else begin
      // the reply to a beat accepted on this edge cannot leave before the next one
      if (m_tvalid && m_tready) begin
        if (queued_replies.size() == 0) begin
          report_mismatch("output beat with no reply outstanding", m_tdata[63:0], '0);
        end else begin
          want = queued_replies.pop_front();
          if (m_tdata[1:0] !== want.status)
            report_mismatch("status", m_tdata[1:0], want.status);
          if (m_tdata[6:2] !== want.position)
            report_mismatch("position", m_tdata[6:2], want.position);
          if (m_tdata[22:7] !== want.found_offset)
            report_mismatch("found_offset", m_tdata[22:7], want.found_offset);
          if (m_tdata[86:23] !== want.found_value)
            report_mismatch("found_value", m_tdata[86:23], want.found_value);
          if (m_tdata[91:87] !== want.point_count)
            report_mismatch("point_count", m_tdata[91:87], want.point_count);
          if (m_tdata[95:92] !== 4'd0)
            report_mismatch("tdata padding", m_tdata[95:92], '0);
        end
      end
      if (s_tvalid && s_tready) begin
        fresh = apply_point_op(s_tuser, s_tdata[15:0], s_tdata[79:16], s_tdata[95:80]);
        queued_replies = {queued_replies, fresh};
      end
    end
    pending <= queued_replies.size();
    errors  <= error_tally;
  end

endmodule

FILE: sim/sorted_point_queue_core_test.sv
`timescale 1ns / 1ps
// Testbench top for sorted_point_queue_core: drives add/get/clear/unused beats with
// random gaps and back-pressure. Depends on spq_pkg, the core and spq_result_checker.
module sorted_point_queue_core_test;
  import spq_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_TAIL   = 200;
  localparam int CYCLE_LIMIT  = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;

  int pending, errors, replaces, full_drops, bad_gets;
  int cycle_count = 0;
  int sent_adds = 0, sent_gets = 0, sent_clears = 0, sent_unused = 0;
  bit drain_only = 1'b0;

  sorted_point_queue_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  spq_result_checker point_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .pending(pending), .errors(errors), .replaces(replaces),
    .full_drops(full_drops), .bad_gets(bad_gets)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: random stall bursts, none in the tail of the run.
  initial begin
    @(posedge clk);
    forever begin
      if (!drain_only && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_point_op(input logic [1:0] func, input logic [15:0] off,
                               input logic [63:0] val, input logic [15:0] idx);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {idx, val, off};
    do @(posedge clk); while (!s_tready);
    case (func)
      OP_ADD:   sent_adds++;
      OP_GET:   sent_gets++;
      OP_CLEAR: sent_clears++;
      default:  sent_unused++;
    endcase
  endtask

  task automatic idle_sender(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every reply has come back.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] random_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : stimulus
    logic [15:0] recent_offsets [8];
    logic [15:0] off;
    logic [15:0] idx;
    int i;
    int k;
    int pick;
    bit sender_gaps;

    foreach (recent_offsets[k]) recent_offsets[k] = '0;
    sender_gaps = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, edge offsets, replace, fill to full, drop and replace at full
    send_point_op(OP_GET, '0, '0, 16'd0);
    send_point_op(OP_CLEAR, '0, '0, '0);
    send_point_op(FUNC_UNUSED, 16'h1234, '1, 16'h0001);
    send_point_op(OP_ADD, 16'h0000, 64'd0, '0);
    send_point_op(OP_ADD, 16'hFFFF, '1, '0);
    send_point_op(OP_ADD, 16'h8000, 64'hA5A5_A5A5_5A5A_5A5A, '0);
    send_point_op(OP_ADD, 16'h8000, 64'h0123_4567_89AB_CDEF, '0);
    send_point_op(OP_GET, '0, '0, 16'd3);
    send_point_op(OP_GET, '0, '0, 16'hFFFF);
    for (k = 13; k >= 1; k--)
      send_point_op(OP_ADD, k[15:0], random_value(), '0);
    send_point_op(OP_ADD, 16'h4000, random_value(), '0);
    send_point_op(OP_ADD, 16'd7, '1, '0);
    send_point_op(OP_GET, '0, '0, 16'd15);
    send_point_op(OP_GET, '0, '0, 16'd16);
    send_point_op(OP_CLEAR, '0, '0, '0);
    wait_for_drain();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 600 || i == 1200) wait_for_drain();
      if (i >= RANDOM_ITEMS - QUIET_TAIL) drain_only = 1'b1;
      if (i % 64 == 0) sender_gaps = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        // mostly a small offset range so lists fill up and offsets repeat
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: off = 16'($urandom_range(0, 40));
          6, 7:             off = 16'($urandom);
          8:                off = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default:          off = recent_offsets[$urandom_range(0, 7)];
        endcase
        recent_offsets[sent_adds % 8] = off;
        send_point_op(OP_ADD, off, random_value(), 16'($urandom));
      end else if (pick < 96) begin
        case ($urandom_range(0, 19))
          0:       idx = 16'($urandom);
          1:       idx = 16'hFFFF;
          default: idx = 16'($urandom_range(0, 17));
        endcase
        send_point_op(OP_GET, 16'($urandom), random_value(), idx);
      end else if (pick < 99) begin
        send_point_op(OP_CLEAR, 16'($urandom), random_value(), 16'($urandom));
      end else begin
        send_point_op(FUNC_UNUSED, 16'($urandom), random_value(), 16'($urandom));
      end
      if (!drain_only && sender_gaps && $urandom_range(0, 5) == 0)
        idle_sender($urandom_range(1, 11));
    end
    wait_for_drain();

    $display("Sent %0d adds, %0d gets, %0d clears, %0d unused-code beats",
             sent_adds, sent_gets, sent_clears, sent_unused);
    $display("Seen %0d value replaces, %0d drops on a full list, %0d out-of-range gets",
             replaces, full_drops, bad_gets);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sorted_point_queue_core.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_point_queue_core.sv
sv/spq_checker.sv
sim/spq_result_checker.sv
sim/sorted_point_queue_core_test.sv
